/* rtl/core/pwm_fade_ramp_assert.svh */
// ----------------------------------------------------------------------------
// pwm_fade_ramp assertion macros
// Short forms for clocked assertions that are disabled while reset is low.
// They expect signals named clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef PWM_FADE_RAMP_ASSERT_SVH
`define PWM_FADE_RAMP_ASSERT_SVH

// Same-cycle implication: when cond holds, expr holds at the same edge.
`define PFR_ASSERT_IMP(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication: when cond holds, expr holds at the following edge.
`define PFR_ASSERT_NXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

/* rtl/core/pfr_pkg.sv */
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared widths, types, register indexes and controller command structs for
// the PWM fade ramp.
// ----------------------------------------------------------------------------
package pfr_pkg;

	// Ramp timer period in milliseconds.
	localparam int TICK_MS = 10;
	// 1.0 in Q.16.
	localparam int ONE_Q16 = 65536;

	localparam int LEVEL_W    = 17;
	localparam int STEP_W     = 28;
	localparam int DUR_W      = 24;
	localparam int ADJ_W      = 19;
	localparam int LIM_W      = 18;
	localparam int DUTY_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	// Largest dividend is the full-scale difference times the tick period.
	localparam int DIVIDEND_W = $clog2(ONE_Q16 * TICK_MS + 1);
	localparam int DIV_STEPS  = DIVIDEND_W;
	localparam int CNT_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	// Product path: the positive level*gain product fits in P_W bits and is
	// split into two halves for the limit multiply.
	localparam int MUL_W   = 21;
	localparam int P_W     = 38;
	localparam int P_LO_W  = 19;
	localparam int P_HI_W  = P_W - P_LO_W;
	localparam int PART_W  = 38;
	localparam int PROD_W  = 58;
	localparam int PC_W    = 49;
	localparam int ROUND_W = 57;

	typedef logic        [LEVEL_W-1:0]    level_t;
	typedef logic signed [LEVEL_W:0]      diff_t;
	typedef logic signed [STEP_W-1:0]     step_t;
	typedef logic signed [STEP_W:0]       sum_t;
	typedef logic        [DUR_W-1:0]      dur_t;
	typedef logic        [DUR_W:0]        trial_t;
	typedef logic        [DIVIDEND_W-1:0] dividend_t;
	typedef logic signed [ADJ_W-1:0]      adj_t;
	typedef logic        [LIM_W-1:0]      lim_t;
	typedef logic signed [ADJ_W:0]        gain_t;
	typedef logic signed [MUL_W-1:0]      mul_op_t;
	typedef logic signed [2*MUL_W-1:0]    mul_res_t;
	typedef logic        [PART_W-1:0]     part_t;
	typedef logic        [PROD_W-1:0]     prod_t;
	typedef logic        [PC_W-1:0]       pc_t;
	typedef logic        [ROUND_W-1:0]    round_t;
	typedef logic        [DUTY_W-1:0]     duty_t;
	typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic        [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic        [CNT_W-1:0]      cnt_t;

	localparam prod_t  ONE_Q48    = prod_t'(1) << 48;
	localparam round_t ROUND_HALF = round_t'(1) << 47;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POWER_ADJUST = 2'd0,
		REG_POWER_LIMIT  = 2'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		MUL_GAIN,
		MUL_LO,
		MUL_HI
	} mul_sel_t;

	typedef struct packed {
		logic     accept;
		logic     div_step;
		logic     div_wb;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sum_en;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic req_is_run;
	} ctrl_sts_t;

endpackage

/* rtl/core/pfr_if.sv */
// ----------------------------------------------------------------------------
// pfr_if
// Valid/ready channels of the PWM fade ramp: request items in, duty items out.
// ----------------------------------------------------------------------------
interface pfr_req_if;
	logic                  valid;
	logic                  ready;
	logic                  mode;
	pfr_pkg::level_t       target_level;
	pfr_pkg::dur_t         duration_ms;
	logic                  tick_elapsed;

	modport source (output valid, output mode, output target_level,
		output duration_ms, output tick_elapsed, input ready);
	modport sink (input valid, input mode, input target_level,
		input duration_ms, input tick_elapsed, output ready);
endinterface

interface pfr_rsp_if;
	logic                  valid;
	logic                  ready;
	pfr_pkg::duty_t        duty;
	logic                  ramping;

	modport source (output valid, output duty, output ramping, input ready);
	modport sink (input valid, input duty, input ramping, output ready);
endinterface

/* rtl/core/pfr_datapath.sv */
// ----------------------------------------------------------------------------
// pfr_datapath
// Ramp state, configuration registers, serial step divider, shared duty
// multiplier and the output register.
// ----------------------------------------------------------------------------
module pfr_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfr_pkg::ctrl_cmd_t   cmd,
	output pfr_pkg::ctrl_sts_t   sts,
	input  logic                 mode,
	input  pfr_pkg::level_t      target_level,
	input  pfr_pkg::dur_t        duration_ms,
	input  logic                 tick_elapsed,
	input  logic                 cfg_we,
	input  pfr_pkg::cfg_idx_t    cfg_index,
	input  pfr_pkg::cfg_data_t   cfg_wdata,
	output pfr_pkg::duty_t       duty,
	output logic                 ramping
);

	pfr_pkg::level_t     level_q;
	pfr_pkg::level_t     target_q;
	pfr_pkg::step_t      step_q;
	pfr_pkg::adj_t       adj_q;
	pfr_pkg::lim_t       lim_q;

	pfr_pkg::diff_t      diff_q;
	pfr_pkg::dur_t       dur_q;
	pfr_pkg::dur_t       rem_q;
	pfr_pkg::dividend_t  quo_q;

	pfr_pkg::mul_res_t   p_q;
	logic                p_pos_q;
	pfr_pkg::part_t      lo_q;
	pfr_pkg::part_t      hi_q;
	pfr_pkg::pc_t        pc_q;
	pfr_pkg::duty_t      duty_q;
	logic                ramping_q;

	pfr_pkg::level_t     tgt_sat;
	pfr_pkg::diff_t      diff;
	pfr_pkg::level_t     diff_mag;
	pfr_pkg::dividend_t  dividend;
	pfr_pkg::sum_t       sum;
	logic                hit;
	pfr_pkg::trial_t     trial;
	logic                ge;
	pfr_pkg::dur_t       rem_next;
	pfr_pkg::step_t      quo_step;
	pfr_pkg::step_t      step_wb;
	pfr_pkg::gain_t      gain;
	pfr_pkg::mul_op_t    mul_a;
	pfr_pkg::mul_op_t    mul_b;
	pfr_pkg::mul_res_t   mul_p;
	pfr_pkg::prod_t      prod;
	pfr_pkg::round_t     rnd;

	assign sts.req_is_run = mode;

	// Command item: saturate target, form |diff| * TICK_MS for the divider.
	always_comb begin
		tgt_sat  = (target_level > pfr_pkg::level_t'(pfr_pkg::ONE_Q16)) ?
			pfr_pkg::level_t'(pfr_pkg::ONE_Q16) : target_level;
		diff     = pfr_pkg::diff_t'(tgt_sat) - pfr_pkg::diff_t'(level_q);
		diff_mag = pfr_pkg::level_t'(diff[pfr_pkg::LEVEL_W] ? -diff : diff);
		dividend = pfr_pkg::dividend_t'(32'(diff_mag) * 32'(pfr_pkg::TICK_MS));
	end

	// Run item: advance the level and detect reaching or passing the target.
	always_comb begin
		sum = pfr_pkg::sum_t'(level_q);
		if (tick_elapsed) begin
			sum = sum + pfr_pkg::sum_t'(step_q);
		end
		hit = (!step_q[pfr_pkg::STEP_W-1] && sum >= pfr_pkg::sum_t'(target_q)) ||
			(step_q[pfr_pkg::STEP_W-1] && sum <= pfr_pkg::sum_t'(target_q));
	end

	// One restoring division step per cycle; quo_q shifts the dividend out
	// and the quotient in.
	always_comb begin
		trial    = {rem_q, quo_q[pfr_pkg::DIVIDEND_W-1]};
		ge       = trial >= {1'b0, dur_q};
		rem_next = ge ? pfr_pkg::dur_t'(trial - {1'b0, dur_q}) : pfr_pkg::dur_t'(trial);
	end

	// Truncated quotient with the sign of the difference; a zero quotient on
	// a nonzero difference becomes one LSB so the ramp always finishes.
	always_comb begin
		quo_step = pfr_pkg::step_t'(quo_q);
		if (dur_q == '0) begin
			step_wb = pfr_pkg::step_t'(diff_q);
		end else if (quo_step == '0 && diff_q != '0) begin
			step_wb = diff_q[pfr_pkg::LEVEL_W] ? -pfr_pkg::step_t'(1) : pfr_pkg::step_t'(1);
		end else begin
			step_wb = diff_q[pfr_pkg::LEVEL_W] ? -quo_step : quo_step;
		end
	end

	// Shared multiplier operands.
	always_comb begin
		gain = pfr_pkg::gain_t'(adj_q) + pfr_pkg::gain_t'(pfr_pkg::ONE_Q16);
		case (cmd.mul_sel)
			pfr_pkg::MUL_GAIN: begin
				mul_a = pfr_pkg::mul_op_t'(level_q);
				mul_b = pfr_pkg::mul_op_t'(gain);
			end
			pfr_pkg::MUL_LO: begin
				mul_a = pfr_pkg::mul_op_t'(p_q[pfr_pkg::P_LO_W-1:0]);
				mul_b = pfr_pkg::mul_op_t'(lim_q);
			end
			pfr_pkg::MUL_HI: begin
				mul_a = pfr_pkg::mul_op_t'(p_q[pfr_pkg::P_W-1:pfr_pkg::P_LO_W]);
				mul_b = pfr_pkg::mul_op_t'(lim_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		prod = (pfr_pkg::prod_t'(hi_q) << pfr_pkg::P_LO_W) + pfr_pkg::prod_t'(lo_q);
		rnd  = (pfr_pkg::round_t'(pc_q) << 8) - pfr_pkg::round_t'(pc_q) + pfr_pkg::ROUND_HALF;
	end

	// Architectural state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			target_q <= '0;
			step_q   <= '0;
			adj_q    <= '0;
			lim_q    <= pfr_pkg::lim_t'(pfr_pkg::ONE_Q16);
		end else begin
			if (cfg_we && cfg_index == pfr_pkg::REG_POWER_ADJUST) begin
				adj_q <= pfr_pkg::adj_t'(cfg_wdata);
			end else if (cfg_we && cfg_index == pfr_pkg::REG_POWER_LIMIT) begin
				lim_q <= pfr_pkg::lim_t'(cfg_wdata);
			end
			if (cmd.accept && !mode) begin
				target_q <= tgt_sat;
			end
			if (cmd.accept && mode && step_q != '0) begin
				if (hit) begin
					level_q <= target_q;
					step_q  <= '0;
				end else begin
					level_q <= pfr_pkg::level_t'(sum);
				end
			end
			if (cmd.div_wb) begin
				step_q <= step_wb;
			end
		end
	end

	// Working registers, no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.accept && !mode) begin
			diff_q <= diff;
			dur_q  <= duration_ms;
			rem_q  <= '0;
			quo_q  <= dividend;
		end
		if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[pfr_pkg::DIVIDEND_W-2:0], ge};
		end
		if (cmd.mul_en && cmd.mul_sel == pfr_pkg::MUL_GAIN) begin
			p_q     <= mul_p;
			p_pos_q <= !mul_p[2*pfr_pkg::MUL_W-1] && mul_p != '0;
		end
		if (cmd.mul_en && cmd.mul_sel == pfr_pkg::MUL_LO) begin
			lo_q <= pfr_pkg::part_t'(mul_p);
		end
		if (cmd.mul_en && cmd.mul_sel == pfr_pkg::MUL_HI) begin
			hi_q <= pfr_pkg::part_t'(mul_p);
		end
		if (cmd.sum_en) begin
			if (!p_pos_q) begin
				pc_q <= '0;
			end else if (prod > pfr_pkg::ONE_Q48) begin
				pc_q <= pfr_pkg::pc_t'(pfr_pkg::ONE_Q48);
			end else begin
				pc_q <= pfr_pkg::pc_t'(prod);
			end
		end
		if (cmd.out_load) begin
			duty_q    <= rnd[55:48];
			ramping_q <= step_q != '0;
		end
	end

	assign duty    = duty_q;
	assign ramping = ramping_q;

endmodule

/* rtl/core/pfr_ctrl.sv */
// ----------------------------------------------------------------------------
// pfr_ctrl
// Sequencer for the PWM fade ramp: accepts items, runs the divider and the
// multiply chain, and owns the output valid flag.
// ----------------------------------------------------------------------------
`include "pwm_fade_ramp_assert.svh"

module pfr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  pfr_pkg::ctrl_sts_t   sts,
	output pfr_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_DWB,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_SUM,
		S_FIN
	} state_t;

	state_t        state_q;
	pfr_pkg::cnt_t cnt_q;
	logic          out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = pfr_pkg::MUL_GAIN;
		cmd.accept   = (state_q == S_IDLE) && req_valid;
		cmd.div_step = state_q == S_DIV;
		cmd.div_wb   = state_q == S_DWB;
		cmd.sum_en   = state_q == S_SUM;
		cmd.out_load = (state_q == S_FIN) && (!out_valid_q || rsp_ready);
		case (state_q)
			S_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pfr_pkg::MUL_GAIN;
			end
			S_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pfr_pkg::MUL_LO;
			end
			S_MUL3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pfr_pkg::MUL_HI;
			end
			default: begin
				cmd.mul_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result loads the output register; otherwise a taken
			// result empties it.
			if (state_q == S_FIN && (!out_valid_q || rsp_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cnt_q   <= '0;
						state_q <= sts.req_is_run ? S_MUL1 : S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == pfr_pkg::cnt_t'(pfr_pkg::DIV_STEPS - 1)) begin
						state_q <= S_DWB;
					end
				end
				S_DWB:  state_q <= S_IDLE;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_MUL3;
				S_MUL3: state_q <= S_SUM;
				S_SUM:  state_q <= S_FIN;
				S_FIN: begin
					if (!out_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = out_valid_q;

	`PFR_ASSERT_IMP(a_load_free, cmd.out_load, !out_valid_q || rsp_ready, "result overwritten")
	`PFR_ASSERT_NXT(a_cmd_div, cmd.accept && !sts.req_is_run, state_q == S_DIV, "no divide")
	`PFR_ASSERT_NXT(a_run_mul, cmd.accept && sts.req_is_run, state_q == S_MUL1, "no multiply")
	`PFR_ASSERT_IMP(a_cnt_range, state_q == S_DIV,
		cnt_q <= pfr_pkg::cnt_t'(pfr_pkg::DIV_STEPS - 1), "divide count overrun")

endmodule

/* rtl/core/pwm_fade_ramp.sv */
// ----------------------------------------------------------------------------
// pwm_fade_ramp
// Linear fade ramp for one PWM channel with gain correction and limit.
// ----------------------------------------------------------------------------
// How to use this block:
// Items arrive on the req channel and are taken when valid and ready are both
// high. A command item (mode 0) loads a new target and duration and produces
// no result. A run item (mode 1) advances the level by one step when
// tick_elapsed is set and then produces one item on the rsp channel holding
// the duty byte and the ramping flag.
// Only one item is in flight at a time. A command item keeps the block busy
// while it is taken, while the serial step divider forms the quotient bit
// by bit (20 bits here), and while the step is stored. A run item is taken,
// then passes three times through the shared multiplier, one clamp stage and
// one rounding stage that loads the output register, valid in the cycle after.
// The result sits in an output register, so the next item is taken while a
// previous result still waits. If the receiver stalls that long, the block
// holds the new run result in its last stage until the output frees up.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) are taken at any edge
// with cfg_we high; index 0 is the gain correction, index 1 the limit.
// Reset clears level, target and step, sets the limit to 1.0 and the gain
// correction to zero, and leaves the output empty.
module pwm_fade_ramp (
	input  logic                 clk,
	input  logic                 arst_n,
	pfr_req_if.sink              req,
	pfr_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  pfr_pkg::cfg_idx_t    cfg_index,
	input  pfr_pkg::cfg_data_t   cfg_wdata
);

	pfr_pkg::ctrl_cmd_t cmd;
	pfr_pkg::ctrl_sts_t sts;

	// Sequencer: handshakes, divide count and multiply order.
	pfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: ramp state, divider, multiplier and output register.
	pfr_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (req.mode),
		.target_level (req.target_level),
		.duration_ms  (req.duration_ms),
		.tick_elapsed (req.tick_elapsed),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.duty         (rsp.duty),
		.ramping      (rsp.ramping)
	);

endmodule

/* bench/tb_pwm_fade_ramp.sv */
// ----------------------------------------------------------------------------
// tb_pwm_fade_ramp
// Self-checking bench for the PWM fade ramp. Command and run items go in on
// the request channel in random bursts, duty items come back on a stalling
// response channel, and a duty tracker predicts every run result from its own
// copy of level, target, step and the two gain registers.
// ----------------------------------------------------------------------------
import pfr_pkg::*;

typedef struct {
	duty_t duty;
	logic  ramping;
} duty_item_t;

// Tracks the ramp state the block should hold and the duty items still owed.
class duty_tracker;
	level_t     level;
	level_t     target;
	step_t      ramp_step;
	adj_t       adjust;
	lim_t       limit;
	duty_item_t pending_duty[$];
	int         errors;

	function new();
		level     = '0;
		target    = '0;
		ramp_step = '0;
		adjust    = '0;
		limit     = lim_t'(ONE_Q16);
		errors    = 0;
	endfunction

	function void set_reg(cfg_idx_t idx, cfg_data_t data);
		if (idx == REG_POWER_ADJUST)
			adjust = adj_t'(data);
		else if (idx == REG_POWER_LIMIT)
			limit = lim_t'(data);
	endfunction

	// Duty byte for the current level: gain, limit, clamp to 1.0, round half up.
	function duty_t predict_duty();
		longint gain;
		longint prod;
		gain = longint'(ONE_Q16) + longint'(adjust);
		prod = longint'(level) * gain;
		if (prod <= 0)
			return '0;
		prod = prod * longint'(limit);
		if (prod > (longint'(1) << 48))
			prod = longint'(1) << 48;
		return duty_t'((255 * prod + (longint'(1) << 47)) >>> 48);
	endfunction

	function void take_item(logic mode, level_t tgt, dur_t dur, logic tick);
		longint diff;
		longint quot;
		longint lvl;
		duty_item_t res;
		if (mode == 1'b0) begin
			target = (tgt > level_t'(ONE_Q16)) ? level_t'(ONE_Q16) : tgt;
			diff = longint'(target) - longint'(level);
			if (dur == '0) begin
				quot = diff;
			end else begin
				quot = (diff * TICK_MS) / longint'(dur);
				if (quot == 0 && diff != 0)
					quot = (diff > 0) ? 1 : -1;
			end
			ramp_step = step_t'(quot);
		end else begin
			if (ramp_step != '0) begin
				lvl = longint'(level);
				if (tick)
					lvl = lvl + longint'(ramp_step);
				if ((ramp_step >= 0 && lvl >= longint'(target)) ||
						(ramp_step < 0 && lvl <= longint'(target))) begin
					lvl = longint'(target);
					ramp_step = '0;
				end
				level = level_t'(lvl);
			end
			res.duty    = predict_duty();
			res.ramping = (ramp_step != '0);
			pending_duty.push_back(res);
		end
	endfunction

	function void check_duty(duty_t duty, logic ramping);
		duty_item_t want;
		if (pending_duty.size() == 0) begin
			errors++;
			$display("%0t: unexpected duty item, duty %0d ramping %0b",
				$time, duty, ramping);
			return;
		end
		want = pending_duty.pop_front();
		if (duty !== want.duty) begin
			errors++;
			$display("%0t: duty expected %0d, got %0d", $time, want.duty, duty);
		end
		if (ramping !== want.ramping) begin
			errors++;
			$display("%0t: ramping expected %0b, got %0b", $time, want.ramping,
				ramping);
		end
	endfunction

	function int pending();
		return pending_duty.size();
	endfunction
endclass

module tb_pwm_fade_ramp;

	// Item kinds on the request channel.
	localparam logic MODE_CMD = 1'b0;
	localparam logic MODE_RUN = 1'b1;
	// Register indexes the block decodes to nothing.
	localparam cfg_idx_t REG_SPARE_A = cfg_idx_t'(2);
	localparam cfg_idx_t REG_SPARE_B = cfg_idx_t'(3);
	// A command keeps the block busy and produces no item, so after the last
	// duty item we still wait for it to finish before touching the registers
	// or ending the run.
	localparam int SETTLE_CYCLES = 40;
	// Watchdog limit; the slowest correct run stays below it even with long stalls.
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 52;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_wdata;

	pfr_req_if req_ch ();
	pfr_rsp_if rsp_ch ();

	pwm_fade_ramp uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	duty_tracker tracker = new();

	int cycles      = 0;
	int burst_left  = 0;

	// Free-running clock, period 4.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver stalls on a pattern of its own. Every stretch of random length
	// picks a style: always ready, coin flip, mostly stalled, or a fixed
	// periodic stall. That puts back-pressure on the output stage of the
	// block while leaving stretches with no stall at all.
	int stall_style = 0;
	int stall_left  = 0;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_left  = $urandom_range(16, 96);
		end else begin
			stall_left = stall_left - 1;
		end
		case (stall_style)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= 1'($urandom_range(0, 1));
			2: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
			default: rsp_ch.ready <= ((stall_left % 12) >= 5);
		endcase
	end

	// Every accepted duty item is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_duty(rsp_ch.duty, rsp_ch.ramping);
	end

	// Offers one item and holds it until the block takes it. The prediction
	// is booked at the accepting edge. The sender then either keeps valid
	// high for the next item of the burst or drops it for a random gap;
	// the gaps land on every phase of a command or a run.
	task automatic push_item(logic mode, level_t tgt, dur_t dur, logic tick);
		int gap;
		@(negedge clk);
		req_ch.valid        = 1'b1;
		req_ch.mode         = mode;
		req_ch.target_level = tgt;
		req_ch.duration_ms  = dur;
		req_ch.tick_elapsed = tick;
		do @(posedge clk); while (!req_ch.ready);
		tracker.take_item(mode, tgt, dur, tick);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk);
				req_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Run item; the command fields are don't-care here, so they carry noise.
	task automatic push_run(logic tick);
		push_item(MODE_RUN, level_t'($urandom), dur_t'($urandom), tick);
	endtask

	// Command item; tick_elapsed is ignored by the block and carries noise.
	task automatic push_cmd(level_t tgt, dur_t dur);
		push_item(MODE_CMD, tgt, dur, 1'($urandom_range(0, 1)));
	endtask

	// Waits until every predicted duty item has come back, then lets a
	// possible trailing command finish inside the block.
	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (tracker.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(posedge clk);
		tracker.set_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Random target: mostly inside 0..1.0, sometimes the raw 17-bit range
	// (exercising the saturation above 1.0), sometimes an exact extreme.
	function automatic level_t pick_target();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return level_t'(ONE_Q16);
			2: return '1;
			3, 4: return level_t'($urandom);
			default: return level_t'($urandom_range(0, ONE_Q16));
		endcase
	endfunction

	// Random duration: mostly short so ramps finish within a few dozen ticks,
	// with zero, medium and full 24-bit values mixed in.
	function automatic dur_t pick_duration();
		case ($urandom_range(0, 9))
			0, 1: return '0;
			2: return dur_t'($urandom);
			3: return dur_t'($urandom_range(301, 5000));
			default: return dur_t'($urandom_range(1, 300));
		endcase
	endfunction

	// One phase of random traffic. Most of it is a command followed by a
	// train of run items with mostly elapsed ticks, so ramps actually walk
	// to their targets; the rest is back-to-back commands that abort a ramp
	// and lone run items with no tick.
	task automatic random_phase(int count);
		int done;
		int runs;
		done = 0;
		while (done < count) begin
			case ($urandom_range(0, 9))
				0: begin
					push_cmd(pick_target(), pick_duration());
					push_cmd(pick_target(), pick_duration());
					done += 2;
				end
				1: begin
					push_run(1'b0);
					done++;
				end
				default: begin
					push_cmd(pick_target(), pick_duration());
					runs = $urandom_range(1, 30);
					repeat (runs)
						push_run($urandom_range(0, 9) != 0);
					done += runs + 1;
				end
			endcase
		end
	endtask

	// Register settings for the random phases: the gain extremes, a zero
	// limit, a zero gain, random values, and finally back to nominal.
	task automatic set_phase_regs(int phase);
		cfg_data_t adj;
		cfg_data_t lim;
		case (phase)
			0: begin adj = cfg_data_t'(131072);  lim = cfg_data_t'(131072); end
			1: begin adj = cfg_data_t'(-131072); lim = cfg_data_t'(ONE_Q16); end
			2: begin adj = '0;                   lim = '0; end
			3: begin adj = cfg_data_t'(-65536);  lim = cfg_data_t'(131072); end
			4, 5: begin
				adj = cfg_data_t'($urandom_range(0, 262144) - 131072);
				lim = cfg_data_t'($urandom_range(0, 131072));
			end
			default: begin adj = '0; lim = cfg_data_t'(ONE_Q16); end
		endcase
		write_reg(REG_POWER_ADJUST, adj);
		write_reg(REG_POWER_LIMIT, lim);
		// Spare indexes must leave both registers alone.
		write_reg(REG_SPARE_A, cfg_data_t'($urandom));
		write_reg(REG_SPARE_B, cfg_data_t'($urandom));
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.mode         = MODE_CMD;
		req_ch.target_level = '0;
		req_ch.duration_ms  = '0;
		req_ch.tick_elapsed = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, at the reset register values.
		// No ramp pending: level stays at zero.
		push_run(1'b1);
		// Target above 1.0 saturates; zero duration gives the whole step.
		push_cmd('1, '0);
		// Without a tick the level holds and the ramp stays pending.
		push_run(1'b0);
		push_run(1'b1);
		// Same target again: zero difference, nothing pending.
		push_cmd(level_t'(ONE_Q16), dur_t'(5));
		push_run(1'b1);
		// Longest duration: the quotient truncates to zero, step becomes -1.
		push_cmd('0, '1);
		push_run(1'b1);
		push_run(1'b1);
		// Down to one half in steps that land exactly on the target at the
		// third tick; the duty rounds 127.5 up to 128.
		push_cmd(level_t'(32768), dur_t'(30));
		repeat (5) push_run(1'b1);
		// Tiny step downward from a half-scale start.
		push_cmd(level_t'(1), dur_t'(24'h800000));
		push_run(1'b1);
		// Straight to zero in one tick, then a tiny upward step.
		push_cmd('0, '0);
		push_run(1'b1);
		push_cmd(level_t'(1), '1);
		push_run(1'b1);
		push_run(1'b1);
		drain();

		for (int phase = 0; phase < 7; phase++) begin
			set_phase_regs(phase);
			random_phase(PHASE_ITEMS);
			drain();
		end

		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
